/* rtl/core/bca_pkg.sv */
// bca_pkg: shared types and constants of the barometer compensation block
// no dependencies

package bca_pkg;

  // oversampling setting and averaging depth of the running average
  localparam int unsigned OVERSAMPLING  = 3;
  localparam int unsigned AVERAGE_SHIFT = 5;

  localparam int unsigned RAW_W  = 19;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned PRES_W = 18;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned IDX_W  = 2;

  localparam logic [PRES_W-1:0] PRES_MAX  = 18'h3FFFF;
  localparam logic [ACC_W-1:0]  ACC_MAX   = 24'hFFFFFF;
  localparam logic [ACC_W-1:0]  ACC_RESET = 24'd320;

  // datasheet constants
  localparam logic signed [63:0] B6_OFFSET = 64'sd4000;
  localparam logic signed [63:0] X3_BIAS   = 64'sd32768;
  localparam logic signed [31:0] P_C1      = 32'sd3038;
  localparam logic signed [31:0] P_C2      = -32'sd7357;
  localparam logic signed [63:0] P_C3      = 64'sd3791;
  localparam logic signed [31:0] B7_SCALE  = 32'(50000 >> OVERSAMPLING);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_AC_SIGNED   = 2'd0,
    REG_AC_UNSIGNED = 2'd1,
    REG_B_PAIR      = 2'd2,
    REG_M_PAIR      = 2'd3
  } reg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_X1, ST_X2, ST_SQ, ST_T1, ST_B3, ST_X3C, ST_B4M,
    ST_B4, ST_B7, ST_P, ST_PS, ST_PA, ST_PB, ST_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

/* rtl/core/bca_if.sv */
// bca_if: item channels and configuration write channel
// depends on bca_pkg

interface bca_in_if;
  import bca_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [RAW_W-1:0] raw_sample;
  modport source (output valid, func, raw_sample, input ready);
  modport sink   (input valid, func, raw_sample, output ready);
endinterface

interface bca_out_if;
  import bca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [PRES_W-1:0]        pressure;
  logic [PRES_W-1:0]        average_pressure;
  logic                     error;
  modport source (output valid, temperature, pressure, average_pressure, error,
                  input ready);
  modport sink   (input valid, temperature, pressure, average_pressure, error,
                  output ready);
endinterface

interface bca_cfg_if;
  import bca_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/bca_mul.sv */
// bca_mul: iterative signed multiplier, four multiplier bits per cycle
// depends on bca_pkg

module bca_mul import bca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [2:0]         cnt_q, cnt_d;
  logic signed [63:0] acc_q, acc_d, a_q, a_d;
  logic [31:0]        b_q, b_d;
  logic signed [63:0] term;
  logic               last;

  // one radix-16 digit a cycle, top digit signed
  always_comb begin
    last = (cnt_q == 3'd7);
    term = '0;
    if (b_q[0]) term = term + a_q;
    if (b_q[1]) term = term + (a_q <<< 1);
    if (b_q[2]) term = term + (a_q <<< 2);
    if (b_q[3]) term = last ? term - (a_q <<< 3) : term + (a_q <<< 3);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end else if (busy_q) begin
      acc_d = acc_q + term;
      a_d   = a_q <<< 4;
      b_d   = b_q >> 4;
      cnt_d = cnt_q + 3'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

/* rtl/core/bca_div.sv */
// bca_div: unsigned 32-bit restoring divider, one quotient bit per cycle
// depends on bca_pkg

module bca_div import bca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [32:0] trial, diff;
  logic        ge;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    trial  = {rem_q, quo_q[31]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/core/barometer_compensation_average.sv */
// Barometer compensation with running average. A temperature item is stored
// and gives no result. A pressure item runs the integer compensation through
// one iterative multiplier (11 products) and one bit-serial divider
// (2 quotients); input is not ready meanwhile. An item with a missing sample or
// a zero divisor finishes early with error set. The result sits in an output
// register, so the next item may start while it waits.
// depends on bca_pkg, bca_if, bca_mul, bca_div

module barometer_compensation_average import bca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bca_in_if.sink    in_i,
  bca_out_if.source out_o,
  bca_cfg_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] ac_s_q, ac_u_q;
  logic [31:0]      b_pair_q, m_pair_q;
  logic [15:0]      ut_q, ut_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic [RAW_W-1:0]         up_q, up_d;
  logic signed [63:0]       x1_q, x1_d, b6_q, b6_d, sq_q, sq_d, t_q, t_d, b3_q, b3_d;
  logic [16:0]              b4_q, b4_d;
  logic [31:0]              p_q, p_d;
  logic signed [TEMP_W-1:0] temp_q, temp_d;
  logic [PRES_W-1:0]        pres_q, pres_d;
  logic                     neg_q, neg_d, dbl_q, dbl_d, err_q, err_d;

  logic                     ovalid_q, ovalid_d;
  logic signed [TEMP_W-1:0] otemp_q, otemp_d;
  logic [PRES_W-1:0]        opres_q, opres_d, oavg_q, oavg_d;
  logic                     oerr_q, oerr_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [63:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5;
  logic [15:0]        ac6;

  logic signed [63:0] v0, v1, v2;
  logic [31:0]        w0;
  logic [ACC_W:0]     acc_sum;
  logic               in_acc;

  bca_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  bca_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // calibration fields
  assign ac1 = 64'(signed'(ac_s_q[47:32]));
  assign ac2 = 64'(signed'(ac_s_q[31:16]));
  assign ac3 = 64'(signed'(ac_s_q[15:0]));
  assign ac4 = {16'd0, ac_u_q[47:32]};
  assign ac5 = {16'd0, ac_u_q[31:16]};
  assign ac6 = ac_u_q[15:0];
  assign b1  = 64'(signed'(b_pair_q[31:16]));
  assign b2  = 64'(signed'(b_pair_q[15:0]));
  assign mc  = 64'(signed'(m_pair_q[31:16]));
  assign md  = 64'(signed'(m_pair_q[15:0]));

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  function automatic logic [PRES_W-1:0] avg_of(logic [ACC_W-1:0] a);
    logic [ACC_W-1:0] s;
    s = a >> AVERAGE_SHIFT;
    return (s > ACC_W'(PRES_MAX)) ? PRES_MAX : s[PRES_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_s_q   <= '0;
      ac_u_q   <= '0;
      b_pair_q <= '0;
      m_pair_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_AC_SIGNED:   ac_s_q   <= cfg_i.data;
        REG_AC_UNSIGNED: ac_u_q   <= cfg_i.data;
        REG_B_PAIR:      b_pair_q <= cfg_i.data[31:0];
        REG_M_PAIR:      m_pair_q <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_comb begin
    state_d  = state_q;
    ut_d     = ut_q;
    acc_d    = acc_q;
    up_d     = up_q;
    x1_d     = x1_q;
    b6_d     = b6_q;
    sq_d     = sq_q;
    t_d      = t_q;
    b3_d     = b3_q;
    b4_d     = b4_q;
    p_d      = p_q;
    temp_d   = temp_q;
    pres_d   = pres_q;
    neg_d    = neg_q;
    dbl_d    = dbl_q;
    err_d    = err_q;
    ovalid_d = ovalid_q && !out_o.ready;
    otemp_d  = otemp_q;
    opres_d  = opres_q;
    oavg_d   = oavg_q;
    oerr_d   = oerr_q;
    mreq     = '0;
    dreq     = '0;
    v0       = '0;
    v1       = '0;
    v2       = '0;
    w0       = '0;
    acc_sum  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.func) begin
            ut_d = in_i.raw_sample[15:0];
          end else begin
            up_d  = in_i.raw_sample;
            err_d = 1'b0;
            if (ut_q == '0 || in_i.raw_sample == '0) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              mreq.start = 1'b1;
              mreq.a     = 64'(signed'({1'b0, ut_q})) - 64'(signed'({1'b0, ac6}));
              mreq.b     = signed'(ac5);
              state_d    = ST_X1;
            end
          end
        end
      end
      ST_X1: begin
        if (mrsp.done) begin
          v0   = mrsp.prod >>> 15;
          v1   = v0 + md;
          v2   = mc <<< 11;
          x1_d = v0;
          if (v1 == '0) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            neg_d      = v1[63] ^ v2[63];
            dreq.start = 1'b1;
            dreq.num   = v2[63] ? 32'(-v2) : v2[31:0];
            dreq.den   = v1[63] ? 32'(-v1) : v1[31:0];
            state_d    = ST_X2;
          end
        end
      end
      ST_X2: begin
        if (drsp.done) begin
          v0 = neg_q ? -64'(signed'({32'd0, drsp.quo})) : 64'(signed'({32'd0, drsp.quo}));
          v1 = x1_q + v0;
          v2 = (v1 + 64'sd8) >>> 4;
          if (v2 > 64'sd32767)       temp_d = 16'sh7FFF;
          else if (v2 < -64'sd32768) temp_d = 16'sh8000;
          else                       temp_d = v2[15:0];
          b6_d       = v1 - B6_OFFSET;
          mreq.start = 1'b1;
          mreq.a     = v1 - B6_OFFSET;
          mreq.b     = 32'(v1 - B6_OFFSET);
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mrsp.done) begin
          sq_d       = mrsp.prod >>> 12;
          mreq.start = 1'b1;
          mreq.a     = mrsp.prod >>> 12;
          mreq.b     = 32'(b2);
          state_d    = ST_T1;
        end
      end
      ST_T1: begin
        if (mrsp.done) begin
          t_d        = mrsp.prod >>> 11;
          mreq.start = 1'b1;
          mreq.a     = b6_q;
          mreq.b     = 32'(ac2);
          state_d    = ST_B3;
        end
      end
      ST_B3: begin
        if (mrsp.done) begin
          v0         = t_q + (mrsp.prod >>> 11);
          v1         = (ac1 <<< 2) + v0;
          b3_d       = ((v1 <<< OVERSAMPLING) + 64'sd2) >>> 2;
          mreq.start = 1'b1;
          mreq.a     = b6_q;
          mreq.b     = 32'(ac3);
          state_d    = ST_X3C;
        end
      end
      ST_X3C: begin
        if (mrsp.done) begin
          t_d        = mrsp.prod >>> 13;
          mreq.start = 1'b1;
          mreq.a     = sq_q;
          mreq.b     = 32'(b1);
          state_d    = ST_B4M;
        end
      end
      ST_B4M: begin
        if (mrsp.done) begin
          v0         = (t_q + (mrsp.prod >>> 16) + 64'sd2) >>> 2;
          v1         = v0 + X3_BIAS;
          mreq.start = 1'b1;
          mreq.a     = signed'({32'd0, v1[31:0]});
          mreq.b     = signed'(ac4);
          state_d    = ST_B4;
        end
      end
      ST_B4: begin
        if (mrsp.done) begin
          b4_d = mrsp.prod[31:15];
          if (mrsp.prod[31:15] == '0) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            v0         = signed'({45'd0, up_q}) - b3_q;
            mreq.start = 1'b1;
            mreq.a     = signed'({32'd0, v0[31:0]});
            mreq.b     = B7_SCALE;
            state_d    = ST_B7;
          end
        end
      end
      ST_B7: begin
        if (mrsp.done) begin
          w0         = mrsp.prod[31:0];
          dbl_d      = w0[31];
          dreq.start = 1'b1;
          dreq.num   = w0[31] ? w0 : {w0[30:0], 1'b0};
          dreq.den   = {15'd0, b4_q};
          state_d    = ST_P;
        end
      end
      ST_P: begin
        if (drsp.done) begin
          w0         = dbl_q ? {drsp.quo[30:0], 1'b0} : drsp.quo;
          p_d        = w0;
          mreq.start = 1'b1;
          mreq.a     = signed'({40'd0, w0[31:8]});
          mreq.b     = signed'({8'd0, w0[31:8]});
          state_d    = ST_PS;
        end
      end
      ST_PS: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = mrsp.prod;
          mreq.b     = P_C1;
          state_d    = ST_PA;
        end
      end
      ST_PA: begin
        if (mrsp.done) begin
          t_d        = mrsp.prod >>> 16;
          mreq.start = 1'b1;
          mreq.a     = signed'({32'd0, p_q});
          mreq.b     = P_C2;
          state_d    = ST_PB;
        end
      end
      ST_PB: begin
        if (mrsp.done) begin
          v0 = signed'({32'd0, p_q}) + ((t_q + (mrsp.prod >>> 16) + P_C3) >>> 4);
          if (v0 < 0)                                  pres_d = '0;
          else if (v0 > 64'(signed'({46'd0, PRES_MAX}))) pres_d = PRES_MAX;
          else                                         pres_d = v0[PRES_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oerr_d   = err_q;
          if (err_q) begin
            otemp_d = '0;
            opres_d = '0;
            oavg_d  = avg_of(acc_q);
          end else begin
            acc_sum = {1'b0, acc_q} - {1'b0, acc_q >> AVERAGE_SHIFT}
                    + (ACC_W+1)'(pres_q);
            acc_d   = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
            otemp_d = temp_q;
            opres_d = pres_q;
            oavg_d  = avg_of(acc_d);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ut_q     <= '0;
      acc_q    <= ACC_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ut_q     <= ut_d;
      acc_q    <= acc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    x1_q    <= x1_d;
    b6_q    <= b6_d;
    sq_q    <= sq_d;
    t_q     <= t_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
    p_q     <= p_d;
    temp_q  <= temp_d;
    pres_q  <= pres_d;
    neg_q   <= neg_d;
    dbl_q   <= dbl_d;
    err_q   <= err_d;
    otemp_q <= otemp_d;
    opres_q <= opres_d;
    oavg_q  <= oavg_d;
    oerr_q  <= oerr_d;
  end

  assign out_o.valid            = ovalid_q;
  assign out_o.temperature      = otemp_q;
  assign out_o.pressure         = opres_q;
  assign out_o.average_pressure = oavg_q;
  assign out_o.error            = oerr_q;

  // units are only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> !mrsp.busy)
    else $error("multiplier started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy)
    else $error("divider started while busy");

  // a pressure item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.func) |=> (state_q != ST_IDLE))
    else $error("pressure item dropped");

  // failed items report zero pressure and temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error) |-> (out_o.pressure == '0 && out_o.temperature == '0))
    else $error("error item with nonzero fields");

endmodule

/* dv/barometer_compensation_average_tb.sv */
// barometer_compensation_average_tb: random and directed test of the barometer
// compensation block against a scoreboard that predicts every result
// depends on bca_pkg, bca_if and barometer_compensation_average
`timescale 1ns / 100ps

module barometer_compensation_average_tb;
  import bca_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic [PRES_W-1:0]        pressure;
    logic [PRES_W-1:0]        average;
    logic                     error;
  } reading_t;

  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE = 400;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 225;

  // compensation predictor and queue of pending readings
  class compensation_sb;
    logic [CFG_W-1:0] ac_signed, ac_unsigned;
    logic [31:0]      b_pair, m_pair;
    logic [15:0]      raw_temp;
    longint unsigned  acc;
    reading_t         pending[$];
    int               mismatches;

    function new();
      ac_signed = '0; ac_unsigned = '0; b_pair = '0; m_pair = '0;
      raw_temp = '0; acc = ACC_RESET; mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_AC_SIGNED:   ac_signed = data;
        REG_AC_UNSIGNED: ac_unsigned = data;
        REG_B_PAIR:      b_pair = data[31:0];
        REG_M_PAIR:      m_pair = data[31:0];
        default: ;
      endcase
    endfunction

    function logic [PRES_W-1:0] avg_now();
      longint unsigned a;
      a = acc >> AVERAGE_SHIFT;
      return (a > PRES_MAX) ? PRES_MAX : a[PRES_W-1:0];
    endfunction

    // run the datasheet compensation for one accepted item
    function void note_item(logic func, logic [RAW_W-1:0] raw);
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint ut, up, x1, x2, x3, b3, b5, b6, sq, tval, p, pval;
      longint unsigned b4, b7, pq;
      reading_t r;
      if (func) begin
        raw_temp = raw[15:0];
        return;
      end
      ac1 = longint'($signed(ac_signed[47:32]));
      ac2 = longint'($signed(ac_signed[31:16]));
      ac3 = longint'($signed(ac_signed[15:0]));
      ac4 = longint'(ac_unsigned[47:32]);
      ac5 = longint'(ac_unsigned[31:16]);
      ac6 = longint'(ac_unsigned[15:0]);
      b1 = longint'($signed(b_pair[31:16]));
      b2 = longint'($signed(b_pair[15:0]));
      mc = longint'($signed(m_pair[31:16]));
      md = longint'($signed(m_pair[15:0]));
      ut = longint'(raw_temp);
      up = longint'(raw);
      r.temperature = '0; r.pressure = '0; r.average = avg_now(); r.error = 1'b1;
      if (ut == 0 || up == 0) begin
        pending.push_back(r);
        return;
      end
      x1 = ((ut - ac6) * ac5) >>> 15;
      if (x1 + md == 0) begin
        pending.push_back(r);
        return;
      end
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;
      tval = (b5 + 8) >>> 4;
      b6 = b5 - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (longint'(1) << OVERSAMPLING) + 2) >>> 2;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      b4 = ((longint'(ac4) * ((x3 + 32768) & MASK32)) & MASK32) >> 15;
      if (b4 == 0) begin
        pending.push_back(r);
        return;
      end
      b7 = (((up - b3) & MASK32) * (50000 >> OVERSAMPLING)) & MASK32;
      if (b7 < 64'h8000_0000) pq = (b7 * 2) / b4;
      else pq = (b7 / b4) * 2;
      p = longint'(pq & MASK32);
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * 3038) >>> 16;
      x2 = (longint'(-7357) * p) >>> 16;
      pval = p + ((x1 + x2 + 3791) >>> 4);
      if (pval < 0) pval = 0;
      if (pval > PRES_MAX) pval = PRES_MAX;
      if (tval > 32767) tval = 32767;
      if (tval < -32768) tval = -32768;
      acc = acc - (acc >> AVERAGE_SHIFT) + longint'(pval);
      if (acc > ACC_MAX) acc = ACC_MAX;
      r.temperature = tval[15:0];
      r.pressure = pval[PRES_W-1:0];
      r.average = avg_now();
      r.error = 1'b0;
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected reading t=%0d p=%0d", got.temperature, got.pressure));
        return;
      end
      want = pending.pop_front();
      if (got.temperature !== want.temperature)
        report($sformatf("temperature %0d, want %0d", got.temperature, want.temperature));
      if (got.pressure !== want.pressure)
        report($sformatf("pressure %0d, want %0d", got.pressure, want.pressure));
      if (got.average !== want.average)
        report($sformatf("average %0d, want %0d", got.average, want.average));
      if (got.error !== want.error)
        report($sformatf("error %0b, want %0b", got.error, want.error));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned idle_pct;
  int unsigned cycles;
  compensation_sb sb;

  bca_in_if  in_if ();
  bca_out_if out_if ();
  bca_cfg_if cfg_if ();

  barometer_compensation_average i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result sink with random stalls, checks each accepted item
  always @(posedge clk_i) begin
    reading_t got;
    if (out_if.valid && out_if.ready && rst_ni) begin
      got.temperature = out_if.temperature;
      got.pressure = out_if.pressure;
      got.average = out_if.average_pressure;
      got.error = out_if.error;
      sb.check_reading(got);
    end
    out_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  task send_item(logic func, logic [RAW_W-1:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= func;
    in_if.raw_sample <= raw;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(func, raw);
  endtask

  task write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // block drained: all readings in and the sequencer finished
  task wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // calibration set for each phase: typical part, zeros, ones, extremes, random
  task load_calibration(int unsigned phase);
    logic [CFG_W-1:0] s, u, b, m;
    case (phase)
      0: begin
        s = {16'd408, -16'sd72, -16'sd14383};
        u = {16'd32741, 16'd32757, 16'd23153};
        b = {16'd6190, 16'd4};
        m = {-16'sd8711, 16'd2868};
      end
      1: begin s = '0; u = '0; b = '0; m = '0; end
      2: begin s = '1; u = '1; b = 32'hFFFF_FFFF; m = 32'hFFFF_FFFF; end
      3: begin s = {3{16'h7FFF}}; u = {3{16'hFFFF}}; b = {2{16'h7FFF}}; m = {2{16'h7FFF}}; end
      4: begin s = {3{16'h8000}}; u = {16'hFFFF, 16'h0, 16'h0}; b = {2{16'h8000}};
         m = {2{16'h8000}}; end
      5: begin
        s = {16'd408 + 16'($urandom_range(200)), -16'sd72, -16'sd14383};
        u = {16'd32741, rand16(), 16'd23153};
        b = {rand16(), 16'($urandom_range(50))};
        m = {-16'sd8711, 16'd2868 + 16'($urandom_range(100))};
      end
      default: begin
        s = {rand16(), rand16(), rand16()};
        u = {rand16(), rand16(), rand16()};
        b = {rand16(), rand16()};
        m = {rand16(), rand16()};
      end
    endcase
    write_reg(REG_AC_SIGNED, s);
    write_reg(REG_AC_UNSIGNED, u);
    write_reg(REG_B_PAIR, b);
    write_reg(REG_M_PAIR, m);
  endtask

  // mostly plausible temperature and pressure samples, the rest noise
  task random_items(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1))
          send_item(1'b1, RAW_W'($urandom_range(35000, 20000)));
        else
          send_item(1'b0, RAW_W'($urandom_range(330000, 150000)));
      end else begin
        send_item(1'($urandom), RAW_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 23;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.func <= 1'b0;
    in_if.raw_sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_AC_SIGNED;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // reset calibration: zero divisor on every pressure item
    send_item(1'b1, 19'd27898);
    send_item(1'b0, 19'd190744);
    wait_drained();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      load_calibration(ph);
      if (ph == 0) begin
        // missing temperature, missing pressure, field extremes
        send_item(1'b0, 19'd190744);
        send_item(1'b1, 19'd27898);
        send_item(1'b0, 19'd190744);
        send_item(1'b0, 19'd0);
        send_item(1'b0, 19'h7FFFF);
        send_item(1'b0, 19'd1);
        send_item(1'b1, 19'h7FFFF);
        send_item(1'b0, 19'd190744);
        send_item(1'b1, 19'd1);
        send_item(1'b0, 19'd190744);
        send_item(1'b1, 19'h70000);
        send_item(1'b0, 19'd190744);
        send_item(1'b1, 19'd27898);
        repeat (6) send_item(1'b0, 19'd190744);
      end
      // one phase runs without any idling
      idle_pct = (ph == 2) ? 0 : 23;
      random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
